FILE: design/rds_pkg.sv
// Package: constants, types, sine table and microcode ROM of the RDS subcarrier modulator.
package rds_pkg;

  // Buffer and symbol geometry
  localparam int BUFFER_DEPTH       = 256;
  localparam int SAMPLES_PER_SYMBOL = 384;
  localparam int BUF_AW   = $clog2(BUFFER_DEPTH);
  localparam int BIT_IW   = BUF_AW + 3;
  localparam int LEN_W    = BUF_AW + 1;
  localparam int PHASE_W  = $clog2(SAMPLES_PER_SYMBOL);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLES_PER_SYMBOL - 1);
  localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(SAMPLES_PER_SYMBOL / 2);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int LEVEL_W  = 18;
  localparam int GAIN_W   = 16;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  // Shared multiplier and product register
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 17;
  localparam int PROD_W = MUL_AW + MUL_BW;

  // Filter coefficients, Q0.16
  localparam logic signed [MUL_BW-1:0]  COEF_KEEP = 17'sd64881;
  localparam logic signed [LEVEL_W+6:0] COEF_STEP = 25'sd655;
  localparam logic signed [LEVEL_W+6:0] LEVEL_MAX = 25'sd131071;
  localparam logic signed [LEVEL_W+6:0] LEVEL_MIN = -25'sd131072;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_BUFFER_BYTES = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MIX_GAIN     = 2'd1;
  localparam logic [LEN_W-1:0]  BUFFER_BYTES_RST = LEN_W'(1);
  localparam logic [GAIN_W-1:0] MIX_GAIN_RST     = 16'd3277;

  // Item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Sequencer step address
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_FMUL   = 3'd3;
  localparam step_t STEP_FINISH = 3'd7;

  // Datapath action of one control word
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_FETCH  = 3'd1,
    ACT_ENCODE = 3'd2,
    ACT_FMUL   = 3'd3,
    ACT_FADD   = 3'd4,
    ACT_MMUL1  = 3'd5,
    ACT_MMUL2  = 3'd6,
    ACT_FINISH = 3'd7
  } act_e;

  // Jump condition: taken goes to target, else to the next step
  typedef enum logic [1:0] {
    COND_NEVER        = 2'd0,
    COND_NO_SAMPLE    = 2'd1,
    COND_NOT_SYM_START = 2'd2,
    COND_OUT_BUSY     = 2'd3
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Microcode ROM. The finish step falls through to step 0 by counter wrap.
  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    case (step)
      3'd0:    w = '{act: ACT_NONE,   cond: COND_NO_SAMPLE,     target: STEP_IDLE};
      3'd1:    w = '{act: ACT_FETCH,  cond: COND_NOT_SYM_START, target: STEP_FMUL};
      3'd2:    w = '{act: ACT_ENCODE, cond: COND_NEVER,         target: STEP_IDLE};
      3'd3:    w = '{act: ACT_FMUL,   cond: COND_NEVER,         target: STEP_IDLE};
      3'd4:    w = '{act: ACT_FADD,   cond: COND_NEVER,         target: STEP_IDLE};
      3'd5:    w = '{act: ACT_MMUL1,  cond: COND_NEVER,         target: STEP_IDLE};
      3'd6:    w = '{act: ACT_MMUL2,  cond: COND_NEVER,         target: STEP_IDLE};
      3'd7:    w = '{act: ACT_FINISH, cond: COND_OUT_BUSY,      target: STEP_FINISH};
      default: w = '{act: ACT_NONE,   cond: COND_NEVER,         target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Eight-entry sine table, Q1.15, phase step of 135 degrees per entry
  function automatic logic signed [SAMPLE_W-1:0] sine_q15(input logic [2:0] idx);
    logic signed [SAMPLE_W-1:0] s;
    case (idx)
      3'd0:    s = 16'sd0;
      3'd1:    s = 16'sd23170;
      3'd2:    s = -16'sd32768;
      3'd3:    s = 16'sd23170;
      3'd4:    s = 16'sd0;
      3'd5:    s = -16'sd23170;
      3'd6:    s = 16'sd32767;
      3'd7:    s = -16'sd23170;
      default: s = 16'sd0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/rds_if.sv
// Interfaces: input item channel and result channel of the RDS subcarrier modulator.
interface rds_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [rds_pkg::SAMPLE_W-1:0]    sample_in;
  logic        [rds_pkg::BYTE_W-1:0]      load_address;
  logic        [rds_pkg::BYTE_W-1:0]      load_byte;

  modport source (output valid, cmd, sample_in, load_address, load_byte, input ready);
  modport sink   (input valid, cmd, sample_in, load_address, load_byte, output ready);
endinterface

interface rds_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rds_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

FILE: design/rds_subcarrier_modulator.sv
// Top level: microcoded RDS subcarrier modulator with its bit buffer.
// A load beat writes one byte of the 256-byte RDS bit buffer; the sequencer
// stays idle. A sample beat runs the seven-step microprogram (buffer fetch,
// bit encode, filter multiply, filter add, two mix multiplies, round and
// saturate) on one shared 34x17 multiplier. For a sample that does not start
// a symbol the fetch step jumps past the encode step. The finish step waits
// while the result register holds a stalled result. The result register lets
// the next item be accepted while the previous result is still waiting to be
// taken. The buffer has no reset; only bytes that were loaded may be cycled
// through.
module rds_subcarrier_modulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rds_in_if.sink                             in_if_i,
  rds_out_if.source                          out_if_o,
  input  logic                               cfg_we_i,
  input  logic [rds_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic [rds_pkg::CFG_DW-1:0]         cfg_data_i
);

  // Configuration registers
  logic [rds_pkg::LEN_W-1:0]  buffer_bytes_q;
  logic [rds_pkg::GAIN_W-1:0] mix_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_bytes_q <= rds_pkg::BUFFER_BYTES_RST;
      mix_gain_q     <= rds_pkg::MIX_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rds_pkg::CFG_BUFFER_BYTES: buffer_bytes_q <= cfg_data_i[rds_pkg::LEN_W-1:0];
        rds_pkg::CFG_MIX_GAIN:     mix_gain_q     <= cfg_data_i[rds_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  rds_pkg::step_t  step_q, step_d;
  rds_pkg::ucode_t uw;
  logic            jump;
  logic            out_busy;
  logic            in_accept;
  logic            load_accept;
  logic            finish_fire;
  logic [rds_pkg::PHASE_W-1:0] phase_q;

  assign uw          = rds_pkg::ucode(step_q);
  assign in_if_i.ready = (step_q == rds_pkg::STEP_IDLE);
  assign in_accept   = in_if_i.valid && in_if_i.ready;
  assign load_accept = in_accept && (in_if_i.cmd == rds_pkg::CMD_LOAD);
  assign out_busy    = out_if_o.valid && !out_if_o.ready;
  assign finish_fire = (uw.act == rds_pkg::ACT_FINISH) && !out_busy;

  always_comb begin
    case (uw.cond)
      rds_pkg::COND_NEVER:         jump = 1'b0;
      rds_pkg::COND_NO_SAMPLE:     jump = !(in_if_i.valid &&
                                            (in_if_i.cmd == rds_pkg::CMD_SAMPLE));
      rds_pkg::COND_NOT_SYM_START: jump = (phase_q != '0);
      rds_pkg::COND_OUT_BUSY:      jump = out_busy;
      default:                     jump = 1'b0;
    endcase
    step_d = jump ? uw.target : rds_pkg::step_t'(step_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rds_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Sample latch
  logic signed [rds_pkg::SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= in_if_i.sample_in;
    end
  end

  // RDS bit buffer, registered read
  logic [rds_pkg::BYTE_W-1:0] bit_store [rds_pkg::BUFFER_DEPTH];
  logic [rds_pkg::BYTE_W-1:0] rd_byte_q;
  logic [rds_pkg::LEN_W-1:0]  len;
  logic [rds_pkg::BIT_IW:0]   len_bits;
  logic [rds_pkg::BIT_IW-1:0] bit_index_q, bit_index_d;
  logic [rds_pkg::BIT_IW-1:0] fetch_index;
  logic [rds_pkg::BIT_IW:0]   next_index;
  logic                       line_bit;
  logic                       diff_bit_q, diff_bit_d;

  always_ff @(posedge clk_i) begin
    if (load_accept) begin
      bit_store[in_if_i.load_address] <= in_if_i.load_byte;
    end
    if (uw.act == rds_pkg::ACT_FETCH) begin
      rd_byte_q <= bit_store[fetch_index[rds_pkg::BIT_IW-1:3]];
    end
  end

  // Buffer length clamp and bit index wrap
  always_comb begin
    if (buffer_bytes_q == '0) begin
      len = rds_pkg::LEN_W'(1);
    end else if (buffer_bytes_q > rds_pkg::LEN_W'(rds_pkg::BUFFER_DEPTH)) begin
      len = rds_pkg::LEN_W'(rds_pkg::BUFFER_DEPTH);
    end else begin
      len = buffer_bytes_q;
    end
    len_bits    = {len, 3'b000};
    fetch_index = ({1'b0, bit_index_q} >= len_bits) ? '0 : bit_index_q;
    next_index  = {1'b0, bit_index_q} + 1'b1;
    line_bit    = rd_byte_q[3'd7 - bit_index_q[2:0]];
    bit_index_d = bit_index_q;
    diff_bit_d  = diff_bit_q;
    case (uw.act)
      rds_pkg::ACT_FETCH: begin
        // the index restarts only when a new symbol fetches its bit
        if (phase_q == '0) begin
          bit_index_d = fetch_index;
        end
      end
      rds_pkg::ACT_ENCODE: begin
        bit_index_d = (next_index >= len_bits) ? '0 : next_index[rds_pkg::BIT_IW-1:0];
        diff_bit_d  = diff_bit_q ^ line_bit;
      end
      default: ;
    endcase
  end

  // Shared multiplier with operand selection
  logic signed [rds_pkg::MUL_AW-1:0]  mul_a;
  logic signed [rds_pkg::MUL_BW-1:0]  mul_b;
  logic signed [rds_pkg::PROD_W-1:0]  mul_p;
  logic signed [rds_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic signed [rds_pkg::LEVEL_W-1:0] level_q, level_d;

  always_comb begin
    case (uw.act)
      rds_pkg::ACT_FMUL: begin
        mul_a = rds_pkg::MUL_AW'(level_q);
        mul_b = rds_pkg::COEF_KEEP;
      end
      rds_pkg::ACT_MMUL1: begin
        mul_a = rds_pkg::MUL_AW'(level_q);
        mul_b = rds_pkg::MUL_BW'(rds_pkg::sine_q15(phase_q[2:0]));
      end
      rds_pkg::ACT_MMUL2: begin
        mul_a = prod_q[rds_pkg::MUL_AW-1:0];
        mul_b = $signed({1'b0, mix_gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Filter update: round the keep product, then step by +/- 0.01 and clamp
  logic signed [39:0]                fsum;
  logic signed [rds_pkg::LEVEL_W+6:0] lvl;
  logic                              tx;

  always_comb begin
    tx   = (phase_q < rds_pkg::PHASE_HALF) ? diff_bit_q : !diff_bit_q;
    fsum = prod_q[39:0] + 40'sd32768;
    lvl  = $signed(fsum[39:16]) + (tx ? rds_pkg::COEF_STEP : -rds_pkg::COEF_STEP);
    if (lvl > rds_pkg::LEVEL_MAX) begin
      level_d = rds_pkg::LEVEL_MAX[rds_pkg::LEVEL_W-1:0];
    end else if (lvl < rds_pkg::LEVEL_MIN) begin
      level_d = rds_pkg::LEVEL_MIN[rds_pkg::LEVEL_W-1:0];
    end else begin
      level_d = lvl[rds_pkg::LEVEL_W-1:0];
    end
    case (uw.act)
      rds_pkg::ACT_FMUL, rds_pkg::ACT_MMUL1, rds_pkg::ACT_MMUL2: prod_d = mul_p;
      default: prod_d = prod_q;
    endcase
  end

  // Round the mix product to Q1.15, add to the sample, saturate
  logic signed [rds_pkg::PROD_W-1:0]   rsum;
  logic signed [18:0]                  addv;
  logic signed [19:0]                  total;
  logic signed [rds_pkg::SAMPLE_W-1:0] sat;
  logic signed [rds_pkg::SAMPLE_W-1:0] out_q;
  logic                                out_valid_q;

  always_comb begin
    rsum  = prod_q + (rds_pkg::PROD_W'(1) <<< 31);
    addv  = rsum[rds_pkg::PROD_W-1:32];
    total = 20'(sample_q) + 20'(addv);
    if (total > 20'sd32767) begin
      sat = 16'sd32767;
    end else if (total < -20'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = total[rds_pkg::SAMPLE_W-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_index_q <= '0;
      diff_bit_q  <= 1'b0;
      level_q     <= '0;
      phase_q     <= '0;
    end else begin
      bit_index_q <= bit_index_d;
      diff_bit_q  <= diff_bit_d;
      if (uw.act == rds_pkg::ACT_FADD) begin
        level_q <= level_d;
      end
      if (finish_fire) begin
        phase_q <= (phase_q == rds_pkg::PHASE_LAST) ? '0
                   : rds_pkg::PHASE_W'(phase_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (finish_fire) begin
      out_q <= sat;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if_o.valid      = out_valid_q;
  assign out_if_o.sample_out = out_q;

endmodule

FILE: design/rds_checker.sv
// Checker: port-level assertions for the RDS subcarrier modulator, and its bind.
module rds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_cmd_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A load beat leaves the input ready again in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == rds_pkg::CMD_LOAD) |=> in_ready_i)
    else $error("load beat did not return to ready");

  // A sample beat keeps the input closed while its program runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == rds_pkg::CMD_SAMPLE) |=> !in_ready_i)
    else $error("input reopened during sample program");

  // With an empty result register a sample's result appears when its program
  // finishes; mid-symbol the program skips the encode step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == rds_pkg::CMD_SAMPLE) && !out_valid_i
    |-> ##[7:8] out_valid_i)
    else $error("sample result missing");

endmodule

bind rds_subcarrier_modulator rds_checker u_rds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if_i.valid),
  .in_ready_i  (in_if_i.ready),
  .in_cmd_i    (in_if_i.cmd),
  .out_valid_i (out_if_o.valid),
  .out_ready_i (out_if_o.ready)
);

FILE: tb/rds_modulator_checker.sv
// Checker: bit-exact prediction of the RDS subcarrier modulator and comparison of its results.
`timescale 1ns / 1ps

module rds_modulator_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rds_in_if                          in_if_i,
  rds_out_if                         out_if_i,
  input  logic                       cfg_we_i,
  input  logic [rds_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [rds_pkg::CFG_DW-1:0] cfg_data_i,
  output int                         mismatch_count_o,
  output int                         pending_count_o
);

  // Filter and mix constants, Q0.16 and Q1.15
  localparam longint KEEP_Q16   = 64881;
  localparam longint STEP_Q16   = 655;
  localparam longint LVL_HI     = 131071;
  localparam longint LVL_LO     = -131072;
  localparam longint OUT_HI     = 32767;
  localparam longint OUT_LO     = -32768;
  localparam longint ROUND_HALF = 64'sd2147483648;
  localparam int     SINE_Q15_LUT [8] = '{0, 23170, -32768, 23170, 0, -23170, 32767, -23170};

  // Own copy of the block state and settings
  logic [rds_pkg::BYTE_W-1:0]          rds_bytes [rds_pkg::BUFFER_DEPTH];
  logic [rds_pkg::LEN_W-1:0]           bytes_cfg;
  logic [rds_pkg::GAIN_W-1:0]          gain_cfg;
  logic [rds_pkg::PHASE_W-1:0]         sym_phase;
  logic [rds_pkg::BIT_IW-1:0]          bit_pos;
  logic                                diff_level;
  logic signed [rds_pkg::LEVEL_W-1:0]  carrier_level;
  logic signed [rds_pkg::SAMPLE_W-1:0] expected_out_q [$];
  logic signed [rds_pkg::SAMPLE_W-1:0] want;

  initial mismatch_count_o = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] rds check: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // One sample beat: advances the symbol state and returns the modulated sample
  function automatic logic signed [rds_pkg::SAMPLE_W-1:0] modulate(
    input logic signed [rds_pkg::SAMPLE_W-1:0] audio
  );
    int     len_bytes;
    int     next_pos;
    logic   line_bit;
    logic   tx_bit;
    longint lvl;
    longint mixed;
    longint add;
    longint sum;
    // new bit at symbol start, MSB first, differentially encoded
    if (sym_phase == '0) begin
      len_bytes = (bytes_cfg == '0) ? 1 : int'(bytes_cfg);
      if (len_bytes > rds_pkg::BUFFER_DEPTH) len_bytes = rds_pkg::BUFFER_DEPTH;
      if (int'(bit_pos) >= len_bytes * 8) bit_pos = '0;
      line_bit = rds_bytes[bit_pos[rds_pkg::BIT_IW-1:3]][3'd7 - bit_pos[2:0]];
      next_pos = int'(bit_pos) + 1;
      bit_pos = (next_pos >= len_bytes * 8) ? '0 : rds_pkg::BIT_IW'(next_pos);
      diff_level ^= line_bit;
    end
    // Manchester: inverse level in the second half of the symbol
    tx_bit = (sym_phase < rds_pkg::PHASE_HALF) ? diff_level : ~diff_level;
    // one-pole low-pass, rounded, then step towards +/-1
    lvl = (longint'(carrier_level) * KEEP_Q16 + 32768) >>> 16;
    lvl += tx_bit ? STEP_Q16 : -STEP_Q16;
    if (lvl > LVL_HI) lvl = LVL_HI;
    if (lvl < LVL_LO) lvl = LVL_LO;
    carrier_level = rds_pkg::LEVEL_W'(lvl);
    // mix with the carrier, scale, round to Q1.15 and saturate
    mixed = longint'(carrier_level) * longint'(SINE_Q15_LUT[sym_phase[2:0]])
            * longint'(gain_cfg);
    add = (mixed + ROUND_HALF) >>> 32;
    sum = longint'(audio) + add;
    if (sum > OUT_HI) sum = OUT_HI;
    if (sum < OUT_LO) sum = OUT_LO;
    sym_phase = (sym_phase == rds_pkg::PHASE_LAST) ? '0 : sym_phase + 1'b1;
    return rds_pkg::SAMPLE_W'(sum);
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_cfg     = rds_pkg::BUFFER_BYTES_RST;
      gain_cfg      = rds_pkg::MIX_GAIN_RST;
      sym_phase     = '0;
      bit_pos       = '0;
      diff_level    = 1'b0;
      carrier_level = '0;
      expected_out_q.delete();
      pending_count_o <= 0;
    end else begin
      // register writes; spare indexes change nothing
      if (cfg_we_i) begin
        if (cfg_index_i == rds_pkg::CFG_BUFFER_BYTES)
          bytes_cfg = cfg_data_i[rds_pkg::LEN_W-1:0];
        else if (cfg_index_i == rds_pkg::CFG_MIX_GAIN)
          gain_cfg = cfg_data_i[rds_pkg::GAIN_W-1:0];
      end
      // result beat first, so a beat taken in the same cycle cannot match itself
      if (out_if_i.valid && out_if_i.ready) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no prediction waiting",
                                    out_if_i.sample_out));
        end else begin
          want = expected_out_q.pop_front();
          if (out_if_i.sample_out !== want)
            report_mismatch($sformatf("sample_out expected %0d, got %0d",
                                      want, out_if_i.sample_out));
        end
      end
      // input beat: loads only touch the byte store
      if (in_if_i.valid && in_if_i.ready) begin
        if (in_if_i.cmd == rds_pkg::CMD_LOAD)
          rds_bytes[in_if_i.load_address] = in_if_i.load_byte;
        else
          expected_out_q.push_back(modulate(in_if_i.sample_in));
      end
      pending_count_o <= expected_out_q.size();
    end
  end

endmodule

FILE: tb/rds_subcarrier_modulator_tb.sv
// Testbench top: clock, reset, stimulus, back-pressure and verdict for the RDS subcarrier modulator.
`timescale 1ns / 1ps

module rds_subcarrier_modulator_tb;

  localparam logic [rds_pkg::CFG_IW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [rds_pkg::CFG_IW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 175;
  localparam int HOLD_CYCLES    = 300;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [rds_pkg::CFG_IW-1:0]       cfg_index_i;
  logic [rds_pkg::CFG_DW-1:0]       cfg_data_i;
  int                               mismatch_count;
  int                               pending_count;
  int                               send_idle_pct;
  int                               recv_idle_pct;
  int                               hold_req_len;
  int                               hold_req_seq;
  logic [rds_pkg::BUFFER_DEPTH-1:0] loaded_map;

  rds_in_if  in_if ();
  rds_out_if out_if ();

  rds_subcarrier_modulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if_i     (in_if),
    .out_if_o    (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  rds_modulator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_if_i          (in_if),
    .out_if_i         (out_if),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls plus an occasional long hold-off on request
  initial begin : receiver
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req_seq != seen_seq) begin
        seen_seq  = hold_req_seq;
        hold_left = hold_req_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after too long without any beat or register write
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("rds_subcarrier_modulator regression: fail");
    $finish;
  end

  // Offer one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic cmd,
                           input logic [rds_pkg::SAMPLE_W-1:0] audio,
                           input logic [rds_pkg::BYTE_W-1:0] addr,
                           input logic [rds_pkg::BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.sample_in    <= audio;
    in_if.load_address <= addr;
    in_if.load_byte    <= data;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == rds_pkg::CMD_LOAD) loaded_map[addr] = 1'b1;
  endtask

  task automatic send_load(input logic [rds_pkg::BYTE_W-1:0] addr,
                           input logic [rds_pkg::BYTE_W-1:0] data);
    send_beat(rds_pkg::CMD_LOAD, rds_pkg::SAMPLE_W'($urandom()), addr, data);
  endtask

  task automatic send_sample(input logic [rds_pkg::SAMPLE_W-1:0] audio);
    send_beat(rds_pkg::CMD_SAMPLE, audio, rds_pkg::BYTE_W'($urandom()),
              rds_pkg::BYTE_W'($urandom()));
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers plus a spare index, back to back
  task automatic write_settings(input logic [rds_pkg::CFG_DW-1:0] bytes_word,
                                input logic [rds_pkg::CFG_DW-1:0] gain_word);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= rds_pkg::CFG_BUFFER_BYTES;
    cfg_data_i  <= bytes_word;
    @(posedge clk_i);
    cfg_index_i <= rds_pkg::CFG_MIX_GAIN;
    cfg_data_i  <= gain_word;
    @(posedge clk_i);
    cfg_index_i <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_data_i  <= rds_pkg::CFG_DW'($urandom());
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [rds_pkg::CFG_DW-1:0]   bytes_word;
    logic [rds_pkg::CFG_DW-1:0]   gain_word;
    logic [rds_pkg::SAMPLE_W-1:0] audio;
    int                           len;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= rds_pkg::CMD_SAMPLE;
    in_if.sample_in    <= '0;
    in_if.load_address <= '0;
    in_if.load_byte    <= '0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= '0;
    cfg_data_i         <= '0;
    send_idle_pct      <= 0;
    recv_idle_pct      <= 0;
    hold_req_len       <= 0;
    hold_req_seq       <= 0;
    loaded_map          = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings; byte 0 goes first since the first symbol reads it
    send_load(8'h00, 8'hB4);
    send_load(8'hFF, 8'h00);
    send_load(8'hAA, 8'h55);
    send_load(8'h55, 8'hAA);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h7FF0);
    send_sample(16'h8010);

    // Random phases, each under its own settings, in one of three idling modes
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: begin bytes_word = 16'h0000; gain_word = 16'hFFFF; end
        1: begin bytes_word = 16'h0100; gain_word = 16'h0000; end
        2: begin bytes_word = 16'hFFFF; gain_word = rds_pkg::CFG_DW'($urandom()); end
        3: begin bytes_word = 16'h0001; gain_word = rds_pkg::CFG_DW'($urandom()); end
        4: begin
          bytes_word = rds_pkg::CFG_DW'($urandom_range(256, 1));
          gain_word  = rds_pkg::CFG_DW'($urandom());
        end
        5: begin bytes_word = 16'hFE03; gain_word = 16'hFFFF; end
        6: begin
          bytes_word = rds_pkg::CFG_DW'($urandom_range(511));
          gain_word  = rds_pkg::CFG_DW'($urandom());
        end
        default: begin bytes_word = 16'h0100; gain_word = 16'hFFFF; end
      endcase
      write_settings(bytes_word, gain_word);
      send_idle_pct <= (p < 3) ? 28 : ((p < 6) ? 69 : 0);
      recv_idle_pct <= (p < 3) ? 69 : ((p < 6) ? 28 : 0);

      // every byte the symbol fetch can reach must hold data first
      len = (bytes_word[rds_pkg::LEN_W-1:0] == '0) ? 1
            : int'(bytes_word[rds_pkg::LEN_W-1:0]);
      if (len > rds_pkg::BUFFER_DEPTH) len = rds_pkg::BUFFER_DEPTH;
      for (int a = 0; a < len; a++)
        if (!loaded_map[a]) send_load(rds_pkg::BYTE_W'(a), rds_pkg::BYTE_W'($urandom()));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while beats keep coming
        if (p == 1 && n == 40) begin
          hold_req_len <= HOLD_CYCLES;
          hold_req_seq <= hold_req_seq + 1;
        end
        if ($urandom_range(99) < 15) begin
          send_load(rds_pkg::BYTE_W'($urandom()), rds_pkg::BYTE_W'($urandom()));
        end else begin
          // near-full-scale audio now and then to reach output saturation
          case ($urandom_range(9))
            0:       audio = 16'h7FFF - rds_pkg::SAMPLE_W'($urandom_range(300));
            1:       audio = 16'h8000 + rds_pkg::SAMPLE_W'($urandom_range(300));
            default: audio = rds_pkg::SAMPLE_W'($urandom());
          endcase
          send_sample(audio);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0 && pending_count == 0)
      $display("rds_subcarrier_modulator regression: pass");
    else
      $display("rds_subcarrier_modulator regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
design/rds_pkg.sv
design/rds_if.sv
design/rds_subcarrier_modulator.sv
design/rds_checker.sv
tb/rds_modulator_checker.sv
tb/rds_subcarrier_modulator_tb.sv
